### sv/assert_macros.svh
// Assertion macros for the RTL files that carry checks (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr))

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### sv/u2c_pkg.sv
// Types, constants and the month length table of the epoch-to-calendar block.
package u2c_pkg;

    localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN    = 6'd60;
    localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;

    // Reciprocals: seconds>>7 by 675, seconds>>4 by 225, seconds>>2 by 15, days by 1461.
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam logic [25:0] RECIP_HOUR = 26'd9321;
    localparam logic [25:0] RECIP_MIN  = 26'd1093;
    localparam logic [25:0] RECIP_QUAD = 26'd91868;

    // Day index of 2100-03-01 counted from 1970-01-01.
    localparam logic [15:0] DAY_MAR1_2100  = 16'd47541;
    localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
    localparam logic [11:0] YEAR_BEFORE_EPOCH = 12'd1969;

    localparam logic [10:0] QUAD_YEAR1 = 11'd365;
    localparam logic [10:0] QUAD_YEAR2 = 11'd730;
    localparam logic [10:0] QUAD_YEAR3 = 11'd1095;

    localparam logic [3:0]  MONTH_DEC  = 4'd11;

    // Division phases.
    localparam logic [1:0] DIV_DAY  = 2'd0;
    localparam logic [1:0] DIV_HOUR = 2'd1;
    localparam logic [1:0] DIV_MIN  = 2'd2;
    localparam logic [1:0] DIV_QUAD = 2'd3;

    typedef struct packed {
        logic       load;
        logic [1:0] sel;
        logic       step;
        logic       year;
        logic       month_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic month_done;
        logic out_free;
    } t_status;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### sv/u2c_if.sv
// Valid/ready channel interfaces for the input and result transfers.
interface u2c_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface u2c_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

### sv/u2c_datapath.sv
// Datapath: shared reciprocal multiplier, year and month resolution, result register.
module u2c_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u2c_pkg::t_cmd   i_cmd,
    output u2c_pkg::t_status o_status,
    input  logic [31:0]     i_seconds,
    u2c_out_if.source       o_out
);

    logic [31:0] r_num;
    logic [15:0] r_quo;
    logic [1:0]  r_sel;
    logic [15:0] r_days;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;
    logic [11:0] r_year;
    logic [8:0]  r_doy;
    logic        r_leap;
    logic [3:0]  r_mon;

    logic        r_ovalid;
    logic [11:0] r_oyear;
    logic [3:0]  r_omonth;
    logic [4:0]  r_oday;
    logic [4:0]  r_ohour;
    logic [5:0]  r_ominute;
    logic [5:0]  r_osecond;

    logic [16:0] w_div;
    logic [24:0] w_x;
    logic [25:0] w_recip;
    logic [50:0] w_prod;
    logic [15:0] w_quo;
    logic [32:0] w_back;
    logic [16:0] w_rem;
    logic [15:0] w_dshift;
    logic [31:0] n_num;
    logic [10:0] w_qrem;
    logic [10:0] w_doy;
    logic [1:0]  w_k;
    logic [4:0]  w_mlen;

    always_comb begin
        unique case (r_sel)
            u2c_pkg::DIV_DAY: begin
                w_div   = u2c_pkg::SEC_PER_DAY;
                w_x     = r_num[31:7];
                w_recip = u2c_pkg::RECIP_DAY;
            end
            u2c_pkg::DIV_HOUR: begin
                w_div   = {5'd0, u2c_pkg::SEC_PER_HOUR};
                w_x     = {12'd0, r_num[16:4]};
                w_recip = u2c_pkg::RECIP_HOUR;
            end
            u2c_pkg::DIV_MIN: begin
                w_div   = {11'd0, u2c_pkg::SEC_PER_MIN};
                w_x     = {15'd0, r_num[11:2]};
                w_recip = u2c_pkg::RECIP_MIN;
            end
            u2c_pkg::DIV_QUAD: begin
                w_div   = {6'd0, u2c_pkg::DAYS_PER_QUAD};
                w_x     = {9'd0, r_num[15:0]};
                w_recip = u2c_pkg::RECIP_QUAD;
            end
        endcase
    end

    assign w_prod = {26'd0, w_x} * {25'd0, w_recip};

    always_comb begin
        unique case (r_sel)
            u2c_pkg::DIV_DAY:  w_quo = w_prod[50:35];
            u2c_pkg::DIV_HOUR: w_quo = {11'd0, w_prod[25:21]};
            u2c_pkg::DIV_MIN:  w_quo = {10'd0, w_prod[19:14]};
            u2c_pkg::DIV_QUAD: w_quo = {10'd0, w_prod[32:27]};
        endcase
    end

    assign w_back = {17'd0, r_quo} * {16'd0, w_div};
    assign w_rem  = r_num[16:0] - w_back[16:0];

    // Skip the nonexistent 2100-02-29 so the four-year cycle stays regular.
    assign w_dshift = r_days + u2c_pkg::DAYS_PER_YEAR
                    + {15'd0, (r_days >= u2c_pkg::DAY_MAR1_2100)};

    always_comb begin
        unique case (i_cmd.sel)
            u2c_pkg::DIV_DAY:  n_num = i_seconds;
            u2c_pkg::DIV_HOUR: n_num = {15'd0, w_rem};
            u2c_pkg::DIV_MIN:  n_num = {15'd0, w_rem};
            u2c_pkg::DIV_QUAD: n_num = {16'd0, w_dshift};
        endcase
    end

    assign w_qrem = w_rem[10:0];

    always_comb begin
        priority if (w_qrem >= u2c_pkg::QUAD_YEAR3) begin
            w_k   = 2'd3;
            w_doy = w_qrem - u2c_pkg::QUAD_YEAR3;
        end else if (w_qrem >= u2c_pkg::QUAD_YEAR2) begin
            w_k   = 2'd2;
            w_doy = w_qrem - u2c_pkg::QUAD_YEAR2;
        end else if (w_qrem >= u2c_pkg::QUAD_YEAR1) begin
            w_k   = 2'd1;
            w_doy = w_qrem - u2c_pkg::QUAD_YEAR1;
        end else begin
            w_k   = 2'd0;
            w_doy = w_qrem;
        end
    end

    assign w_mlen = u2c_pkg::month_len(r_leap, r_mon);

    assign o_status.month_done = (r_mon == u2c_pkg::MONTH_DEC) || (r_doy < {4'd0, w_mlen});
    assign o_status.out_free   = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= n_num;
            unique case (i_cmd.sel)
                u2c_pkg::DIV_DAY:  ;
                u2c_pkg::DIV_HOUR: r_days <= r_quo;
                u2c_pkg::DIV_MIN:  r_hour <= r_quo[4:0];
                u2c_pkg::DIV_QUAD: begin
                    r_min <= r_quo[5:0];
                    r_sec <= w_rem[5:0];
                end
            endcase
        end else if (i_cmd.step) begin
            r_quo <= w_quo;
        end

        if (i_cmd.year) begin
            r_year <= u2c_pkg::YEAR_BEFORE_EPOCH + {4'd0, r_quo[5:0], 2'd0} + {10'd0, w_k};
            r_doy  <= w_doy[8:0];
            r_leap <= (w_k == 2'd3);
            r_mon  <= 4'd0;
        end else if (i_cmd.month_step) begin
            r_doy <= r_doy - {4'd0, w_mlen};
            r_mon <= r_mon + 4'd1;
        end

        if (i_cmd.out_load) begin
            r_oyear   <= r_year;
            r_omonth  <= r_mon + 4'd1;
            r_oday    <= r_doy[4:0] + 5'd1;
            r_ohour   <= r_hour;
            r_ominute <= r_min;
            r_osecond <= r_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= u2c_pkg::DIV_DAY;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sel <= i_cmd.sel;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid  = r_ovalid;
    assign o_out.year   = r_oyear;
    assign o_out.month  = r_omonth;
    assign o_out.day    = r_oday;
    assign o_out.hour   = r_ohour;
    assign o_out.minute = r_ominute;
    assign o_out.second = r_osecond;

endmodule

### sv/u2c_ctrl.sv
// Controller: sequences the division phases, year resolution and month walk.
module u2c_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  u2c_pkg::t_status i_status,
    output u2c_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_YEAR  = 3'd3;
    localparam logic [2:0] S_MONTH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [1:0] w_next_phase;

    assign w_next_phase = r_phase + 2'd1;
    assign o_in_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = u2c_pkg::DIV_DAY;
                    n_phase    = u2c_pkg::DIV_DAY;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_state    = (r_phase == u2c_pkg::DIV_QUAD) ? S_YEAR : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                o_cmd.sel  = w_next_phase;
                n_phase    = w_next_phase;
                n_state    = S_DIV;
            end
            S_YEAR: begin
                o_cmd.year = 1'b1;
                n_state    = S_MONTH;
            end
            S_MONTH: begin
                if (!i_status.month_done) begin
                    o_cmd.month_step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= u2c_pkg::DIV_DAY;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

### sv/unix_time_to_calendar.sv
// Top level: epoch seconds to UTC calendar date and time.
// Four reciprocal-multiply divisions (days, hours, minutes, four-year blocks), then
// year resolution and a month table walk of one step per month passed; a new input
// is taken only after the previous result has gone to the result register.
// The result register holds a finished item while the next one is taken.
// Reset is synchronous, active low; it clears the controller and result valid.
`include "assert_macros.svh"

module unix_time_to_calendar (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u2c_in_if.sink    i_in,
    u2c_out_if.source o_out
);

    u2c_pkg::t_cmd    w_cmd;
    u2c_pkg::t_status w_status;
    logic             w_in_ready;

    assign i_in.ready = w_in_ready;

    u2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    u2c_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_seconds (i_in.unix_seconds),
        .o_out     (o_out)
    );

    `ASSERT_CLK(a_busy_after_take, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready)
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load && !w_status.out_free)
    `ASSERT_NEVER(a_month_past_end, i_clk, i_rst_n, w_cmd.month_step && w_status.month_done)

endmodule
